// ----- design/matrix3x3_inverse_macros.svh -----
// Assertion macros shared by the matrix inverse design.
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define M3I_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define M3I_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/m3i_pkg.sv -----
// Types, widths, tables and helpers for the 3x3 matrix inverse pipeline.
package m3i_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int N_ELEM    = 9;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int COF_W     = PROD_W + 1;
  localparam int PP_W      = 2 * DATA_W + 1;
  localparam int DET_W     = COF_W + DATA_W + 1;
  localparam int MAG_W     = DET_W;
  localparam int AMAG_W    = PROD_W;
  localparam int NUM_W     = AMAG_W + 2 * FRAC_BITS;
  localparam int HI_W      = NUM_W - DATA_W;
  localparam int REM_W     = MAG_W + 1;

  localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W:0]   SAT_POS   = {1'b0, POS_LIMIT};
  localparam logic [DATA_W:0]   SAT_NEG   = SAT_POS + 1'b1;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef elem_t [N_ELEM-1:0]       mat_t;
  typedef elem_t [2:0]              row_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef cof_t [N_ELEM-1:0]        cof_arr_t;
  typedef logic signed [PP_W-1:0]   pp_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [3:0]               idx_t;

  // cofactor k = m[a]*m[b] - m[c]*m[d]
  localparam idx_t COF_IDX [N_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd1, 4'd5, 4'd2, 4'd4}, '{4'd2, 4'd3, 4'd0, 4'd5}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] low;
  } div_lane_t;

  typedef struct packed {
    logic [MAG_W-1:0]              dmag;
    logic [N_ELEM-1:0]             neg;
    logic [N_ELEM-1:0]             ovf;
    logic                          singular;
    logic [DATA_W-1:0]             det_sat;
    div_lane_t [N_ELEM-1:0]        lane;
  } div_stage_t;

  // Saturate a sign and magnitude to a two's complement word.
  function automatic logic [DATA_W-1:0] sat_val(input logic neg, input logic ovr,
                                                input logic [DATA_W:0] v);
    logic [DATA_W:0] lim;
    logic [DATA_W:0] mag;
    logic [DATA_W:0] res;
    lim = neg ? SAT_NEG : SAT_POS;
    mag = (ovr || (v > lim)) ? lim : v;
    res = neg ? (~mag + 1'b1) : mag;
    return res[DATA_W-1:0];
  endfunction

endpackage

// ----- design/m3i_cof.sv -----
// Cofactor stages: eighteen products, then nine differences.
module m3i_cof
  import m3i_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_v,
  input  mat_t     in_m,
  output logic     out_v,
  output cof_arr_t out_cof,
  output row_t     out_row0
);

  logic                            v1_r, v2_r;
  logic signed [PROD_W-1:0]        pa_r [N_ELEM];
  logic signed [PROD_W-1:0]        pb_r [N_ELEM];
  row_t                            row1_r, row2_r;
  cof_arr_t                        cof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N_ELEM; k++) begin
      pa_r[k]  <= PROD_W'(in_m[COF_IDX[k][0]]) * PROD_W'(in_m[COF_IDX[k][1]]);
      pb_r[k]  <= PROD_W'(in_m[COF_IDX[k][2]]) * PROD_W'(in_m[COF_IDX[k][3]]);
      cof_r[k] <= COF_W'(pa_r[k]) - COF_W'(pb_r[k]);
    end
    row1_r <= in_m[2:0];
    row2_r <= row1_r;
  end

  assign out_v    = v2_r;
  assign out_cof  = cof_r;
  assign out_row0 = row2_r;

endmodule

// ----- design/m3i_det.sv -----
// Determinant stages: split products, shifted terms, three-way sum.
module m3i_det
  import m3i_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_v,
  input  cof_arr_t in_cof,
  input  row_t     in_row0,
  output logic     out_v,
  output cof_arr_t out_cof,
  output det_t     out_det
);

  logic     v3_r, v4_r, v5_r;
  pp_t      lo_r [3];
  pp_t      hi_r [3];
  det_t     term_r [3];
  det_t     det_r;
  cof_arr_t cof3_r, cof4_r, cof5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v3_r <= in_v;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      lo_r[k]   <= PP_W'($signed({1'b0, in_cof[k][DATA_W-1:0]})) * PP_W'(in_row0[k]);
      hi_r[k]   <= PP_W'($signed(in_cof[k][COF_W-1:DATA_W])) * PP_W'(in_row0[k]);
      term_r[k] <= (DET_W'(hi_r[k]) <<< DATA_W) + DET_W'(lo_r[k]);
    end
    det_r  <= term_r[0] + term_r[1] + term_r[2];
    cof3_r <= in_cof;
    cof4_r <= cof3_r;
    cof5_r <= cof4_r;
  end

  assign out_v   = v5_r;
  assign out_cof = cof5_r;
  assign out_det = det_r;

endmodule

// ----- design/m3i_div_step.sv -----
// One restoring-division step for all nine lanes.
module m3i_div_step
  import m3i_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_v,
  input  div_stage_t in_s,
  output logic       out_v,
  output div_stage_t out_s
);

  logic       v_r;
  div_stage_t s_r, s_nxt;

  always_comb begin
    logic [REM_W-1:0] t;
    logic             ge;
    s_nxt = in_s;
    for (int k = 0; k < N_ELEM; k++) begin
      t  = {in_s.lane[k].rem[REM_W-2:0], in_s.lane[k].low[DATA_W-1]};
      ge = (t >= {1'b0, in_s.dmag});
      s_nxt.lane[k].rem = ge ? (t - {1'b0, in_s.dmag}) : t;
      s_nxt.lane[k].q   = {in_s.lane[k].q[DATA_W-2:0], ge};
      s_nxt.lane[k].low = {in_s.lane[k].low[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

  assign out_v = v_r;
  assign out_s = s_r;

endmodule

// ----- design/matrix3x3_inverse.sv -----
// Top level of the 3x3 fixed-point matrix inverse pipeline.
//
// Usage: drive the nine entries of a signed Q16.16 matrix on in_m00..in_m22
// and pulse start. A transaction is taken at every rising edge where start
// is high and busy is low; busy stays low, so one matrix may enter every
// clock cycle, back to back, with no gaps.
// Each result appears on out_r00..out_r22, out_det and out_singular for
// exactly one cycle, marked by out_valid, after its transaction passes the
// product, cofactor, determinant and setup stages, 32 one-bit division
// steps (one per quotient bit), and one saturation stage.
// Throughput is one matrix per cycle; the division chain sets the latency.
// Entries are adjugate / determinant, truncated toward zero and saturated.
// A zero determinant forces all entries to the largest positive value,
// drives out_det to zero and raises out_singular.
// The receiver cannot stall: results are presented once and never held.
// Synchronous active-low reset drops every valid bit in flight; data
// registers are not reset.
module matrix3x3_inverse
  import m3i_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_m00,
  input  logic [31:0] in_m01,
  input  logic [31:0] in_m02,
  input  logic [31:0] in_m10,
  input  logic [31:0] in_m11,
  input  logic [31:0] in_m12,
  input  logic [31:0] in_m20,
  input  logic [31:0] in_m21,
  input  logic [31:0] in_m22,
  output logic        out_valid,
  output logic [31:0] out_r00,
  output logic [31:0] out_r01,
  output logic [31:0] out_r02,
  output logic [31:0] out_r10,
  output logic [31:0] out_r11,
  output logic [31:0] out_r12,
  output logic [31:0] out_r20,
  output logic [31:0] out_r21,
  output logic [31:0] out_r22,
  output logic [31:0] out_det,
  output logic        out_singular
);

  `include "matrix3x3_inverse_macros.svh"

  // Never stall: every stage advances every cycle.
  assign busy = 1'b0;

  mat_t     in_mat;
  logic     cof_v, det_v;
  cof_arr_t cof_c, cof_d;
  row_t     row0_c;
  det_t     det_d;

  assign in_mat = {in_m22, in_m21, in_m20, in_m12, in_m11, in_m10,
                   in_m02, in_m01, in_m00};

  m3i_cof u_cof (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (start && !busy),
    .in_m     (in_mat),
    .out_v    (cof_v),
    .out_cof  (cof_c),
    .out_row0 (row0_c)
  );

  m3i_det u_det (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (cof_v),
    .in_cof  (cof_c),
    .in_row0 (row0_c),
    .out_v   (det_v),
    .out_cof (cof_d),
    .out_det (det_d)
  );

  // Magnitudes and signs; transpose cofactors into adjugate order here.
  logic                           s6_v_r;
  logic [MAG_W-1:0]               s6_dmag_r;
  logic                           s6_dneg_r;
  logic                           s6_sing_r;
  logic [N_ELEM-1:0][AMAG_W-1:0]  s6_amag_r;
  logic [N_ELEM-1:0]              s6_neg_r;

  always_ff @(posedge clk) begin
    s6_dneg_r <= det_d[DET_W-1];
    s6_dmag_r <= det_d[DET_W-1] ? MAG_W'(-det_d) : MAG_W'(det_d);
    s6_sing_r <= (det_d == '0);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s6_amag_r[i*3+j] <= cof_d[j*3+i][COF_W-1] ? AMAG_W'(-cof_d[j*3+i])
                                                   : AMAG_W'(cof_d[j*3+i]);
        s6_neg_r[i*3+j]  <= cof_d[j*3+i][COF_W-1] ^ det_d[DET_W-1];
      end
    end
  end

  // Setup: scale numerators, detect quotient overflow, saturate det.
  logic       s7_v_r;
  div_stage_t s7_s_r, s7_s_nxt;

  always_comb begin
    logic [NUM_W-1:0] num;
    logic [HI_W-1:0]  hi;
    logic [MAG_W-1:0] dsh;
    s7_s_nxt          = '0;
    s7_s_nxt.dmag     = s6_dmag_r;
    s7_s_nxt.neg      = s6_neg_r;
    s7_s_nxt.singular = s6_sing_r;
    dsh               = s6_dmag_r >> (2 * FRAC_BITS);
    s7_s_nxt.det_sat  = sat_val(s6_dneg_r, |dsh[MAG_W-1:DATA_W+1], dsh[DATA_W:0]);
    for (int k = 0; k < N_ELEM; k++) begin
      num = NUM_W'(s6_amag_r[k]) << (2 * FRAC_BITS);
      hi  = num[NUM_W-1:DATA_W];
      s7_s_nxt.ovf[k]      = (MAG_W'(hi) >= s6_dmag_r);
      s7_s_nxt.lane[k].rem = REM_W'(hi);
      s7_s_nxt.lane[k].q   = '0;
      s7_s_nxt.lane[k].low = num[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s7_s_r <= s7_s_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else begin
      s6_v_r <= det_v;
      s7_v_r <= s6_v_r;
    end
  end

  // Division chain: one quotient bit per stage.
  logic       stg_v [DATA_W+1];
  div_stage_t stg_s [DATA_W+1];

  assign stg_v[0] = s7_v_r;
  assign stg_s[0] = s7_s_r;

  for (genvar g = 0; g < DATA_W; g++) begin : g_div
    m3i_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .in_v  (stg_v[g]),
      .in_s  (stg_s[g]),
      .out_v (stg_v[g+1]),
      .out_s (stg_s[g+1])
    );
  end

  // Output stage: saturate, apply sign, force singular results.
  logic                          out_v_r;
  logic [N_ELEM-1:0][DATA_W-1:0] res_r, res_nxt;
  logic [DATA_W-1:0]             det_r, det_nxt;
  logic                          sing_r;
  div_stage_t                    fin;

  assign fin = stg_s[DATA_W];

  always_comb begin
    for (int k = 0; k < N_ELEM; k++) begin
      res_nxt[k] = fin.singular ? POS_LIMIT
                 : sat_val(fin.neg[k], fin.ovf[k], {1'b0, fin.lane[k].q});
    end
    det_nxt = fin.singular ? '0 : fin.det_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= stg_v[DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    det_r  <= det_nxt;
    sing_r <= fin.singular;
  end

  assign out_valid    = out_v_r;
  assign out_r00      = res_r[0];
  assign out_r01      = res_r[1];
  assign out_r02      = res_r[2];
  assign out_r10      = res_r[3];
  assign out_r11      = res_r[4];
  assign out_r12      = res_r[5];
  assign out_r20      = res_r[6];
  assign out_r21      = res_r[7];
  assign out_r22      = res_r[8];
  assign out_det      = det_r;
  assign out_singular = sing_r;

  `M3I_ASSERT_NOW(a_sing_force, clk, rst_n, out_valid && out_singular, (out_r00 == POS_LIMIT) && (out_r11 == POS_LIMIT) && (out_r22 == POS_LIMIT) && (out_det == '0), "singular result not forced")
  `M3I_ASSERT_NEXT(a_chain_out, clk, rst_n, stg_v[DATA_W], out_valid, "division chain result dropped")
  `M3I_ASSERT_NOW(a_det_zero, clk, rst_n, s7_v_r && s7_s_r.singular, s7_s_r.det_sat == '0, "zero determinant saturated nonzero")

endmodule

// ----- tb/sv/tb_matrix3x3_inverse.sv -----
// Self-checking testbench for the 3x3 fixed-point matrix inverse pipeline.
module tb_matrix3x3_inverse;
  import m3i_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 1030;
  localparam int N_DIRECTED = 16;
  localparam int DRAIN_CYC  = 48;    // a little longer than the full pipeline
  localparam int STALL_MAX  = 3000;  // idle cycles before the watchdog trips
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef logic signed [255:0] wide_t;

  // One inverse result as the block presents it.
  typedef struct packed {
    logic [8:0][31:0] r;
    logic [31:0]      det;
    logic             sing;
  } inv_res_t;

  // One directed row: the matrix, plus a hand-typed expectation where obvious.
  typedef struct packed {
    logic [8:0][31:0] m;
    logic             typed;
    inv_res_t         res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_m [9];
  logic        out_valid;
  logic [31:0] out_r [9];
  logic [31:0] out_det;
  logic        out_singular;

  inv_res_t    inverse_q [$];
  stim_row_t   directed [N_DIRECTED];
  int          n_mismatch = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_singular = 0;
  int          n_saturated = 0;
  int          idle_cyc = 0;

  always #4 clk = ~clk;

  matrix3x3_inverse dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_m00(in_m[0]), .in_m01(in_m[1]), .in_m02(in_m[2]),
    .in_m10(in_m[3]), .in_m11(in_m[4]), .in_m12(in_m[5]),
    .in_m20(in_m[6]), .in_m21(in_m[7]), .in_m22(in_m[8]),
    .out_valid(out_valid),
    .out_r00(out_r[0]), .out_r01(out_r[1]), .out_r02(out_r[2]),
    .out_r10(out_r[3]), .out_r11(out_r[4]), .out_r12(out_r[5]),
    .out_r20(out_r[6]), .out_r21(out_r[7]), .out_r22(out_r[8]),
    .out_det(out_det), .out_singular(out_singular)
  );

  // Clamp a sign and magnitude into a signed 32-bit word.
  function automatic logic [31:0] clamp32(input logic neg, input logic [255:0] mag);
    logic [255:0] lim;
    logic [255:0] v;
    lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
    v = (mag > lim) ? lim : mag;
    if (neg) v = -v;
    return v[31:0];
  endfunction

  // Invert one matrix by its adjugate, with the determinant kept at full width.
  function automatic inv_res_t invert_adjugate(input logic [8:0][31:0] m);
    wide_t        e [9];
    wide_t        cof [9];
    wide_t        dfull;
    wide_t        a;
    logic [255:0] dmag;
    logic [255:0] amag;
    logic [255:0] quot;
    inv_res_t     res;
    for (int k = 0; k < 9; k++) e[k] = {{224{m[k][31]}}, m[k]};
    // Cofactors in row-major order, each the usual 2x2 minor with its sign.
    cof[0] = e[4] * e[8] - e[5] * e[7];
    cof[1] = e[5] * e[6] - e[3] * e[8];
    cof[2] = e[3] * e[7] - e[4] * e[6];
    cof[3] = e[2] * e[7] - e[1] * e[8];
    cof[4] = e[0] * e[8] - e[2] * e[6];
    cof[5] = e[1] * e[6] - e[0] * e[7];
    cof[6] = e[1] * e[5] - e[2] * e[4];
    cof[7] = e[2] * e[3] - e[0] * e[5];
    cof[8] = e[0] * e[4] - e[1] * e[3];
    dfull = cof[0] * e[0] + cof[1] * e[1] + cof[2] * e[2];
    res.sing = (dfull == 0);
    if (res.sing) begin
      for (int k = 0; k < 9; k++) res.r[k] = 32'h7FFF_FFFF;
      res.det = '0;
      return res;
    end
    dmag = (dfull < 0) ? -dfull : dfull;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        // Transpose: inverse entry (i,j) comes from cofactor (j,i).
        a = cof[j * 3 + i];
        amag = (a < 0) ? -a : a;
        quot = (amag << (2 * FRAC_BITS)) / dmag;
        res.r[i * 3 + j] = clamp32((a < 0) != (dfull < 0), quot);
      end
    end
    res.det = clamp32(dfull < 0, dmag >> (2 * FRAC_BITS));
    return res;
  endfunction

  function automatic logic [31:0] rand_signed(input int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // Draw a random matrix from one of several shapes.
  function automatic logic [8:0][31:0] rand_matrix();
    logic [8:0][31:0] m;
    int unsigned      pick;
    int unsigned      src;
    int unsigned      dst;
    pick = $urandom_range(0, 99);
    for (int k = 0; k < 9; k++) m[k] = rand_signed(32'h0004_0000);
    if (pick < 20) begin
      // full 32-bit entries: every bit toggles, deep saturation
      for (int k = 0; k < 9; k++) m[k] = $urandom;
    end else if (pick < 35) begin
      // rank deficient: copy or negate one row onto another
      src = $urandom_range(0, 2);
      dst = (src + $urandom_range(1, 2)) % 3;
      for (int c = 0; c < 3; c++)
        m[dst * 3 + c] = $urandom_range(0, 1) ? m[src * 3 + c] : -m[src * 3 + c];
    end else if (pick < 50) begin
      // near identity, the well-conditioned common case
      for (int k = 0; k < 9; k++)
        m[k] = ((k % 4) == 0 ? ONE : 32'h0) + rand_signed(32'h800);
    end else if (pick < 60) begin
      // a few LSBs per entry: tiny determinant, entries overflow
      for (int k = 0; k < 9; k++) m[k] = rand_signed(4);
    end
    return m;
  endfunction

  function automatic stim_row_t diag_row(input logic [31:0] d0, input logic [31:0] d1,
                                         input logic [31:0] d2);
    stim_row_t row;
    row = '0;
    row.m[0] = d0;
    row.m[4] = d1;
    row.m[8] = d2;
    return row;
  endfunction

  // Fill the directed table: extremes, singular cases and saturation.
  initial begin
    for (int k = 0; k < N_DIRECTED; k++) directed[k] = '0;
    // identity inverts to itself
    directed[0] = diag_row(ONE, ONE, ONE);
    directed[0].typed = 1'b1;
    directed[0].res.r[0] = ONE;
    directed[0].res.r[4] = ONE;
    directed[0].res.r[8] = ONE;
    directed[0].res.det = ONE;
    // zero matrix: singular, every entry pinned high
    directed[1].typed = 1'b1;
    directed[1].res.sing = 1'b1;
    for (int k = 0; k < 9; k++) directed[1].res.r[k] = 32'h7FFF_FFFF;
    // all entries at the positive extreme, then the negative one: rank one
    for (int k = 0; k < 9; k++) directed[2].m[k] = 32'h7FFF_FFFF;
    for (int k = 0; k < 9; k++) directed[3].m[k] = 32'h8000_0000;
    directed[2].typed = 1'b1;
    directed[2].res = directed[1].res;
    directed[3].typed = 1'b1;
    directed[3].res = directed[1].res;
    // twice the identity halves
    directed[4] = diag_row(2 * ONE, 2 * ONE, 2 * ONE);
    directed[4].typed = 1'b1;
    directed[4].res.r[0] = ONE / 2;
    directed[4].res.r[4] = ONE / 2;
    directed[4].res.r[8] = ONE / 2;
    directed[4].res.det = 8 * ONE;
    // negative identity
    directed[5] = diag_row(-ONE, -ONE, -ONE);
    directed[5].typed = 1'b1;
    directed[5].res.r[0] = -ONE;
    directed[5].res.r[4] = -ONE;
    directed[5].res.r[8] = -ONE;
    directed[5].res.det = -ONE;
    // one LSB on the diagonal: entries overflow positive, det truncates to zero
    directed[6] = diag_row(32'd1, 32'd1, 32'd1);
    directed[6].typed = 1'b1;
    directed[6].res.r[0] = 32'h7FFF_FFFF;
    directed[6].res.r[4] = 32'h7FFF_FFFF;
    directed[6].res.r[8] = 32'h7FFF_FFFF;
    // same with a negative determinant: the diagonal splits across both limits
    directed[7] = diag_row(-32'sd1, 32'd1, 32'd1);
    directed[7].typed = 1'b1;
    directed[7].res.r[0] = 32'h8000_0000;
    directed[7].res.r[4] = 32'h7FFF_FFFF;
    directed[7].res.r[8] = 32'h7FFF_FFFF;
    // largest diagonal: determinant saturates high
    directed[8] = diag_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    directed[8].typed = 1'b1;
    directed[8].res.r[0] = 32'd2;
    directed[8].res.r[4] = 32'd2;
    directed[8].res.r[8] = 32'd2;
    directed[8].res.det = 32'h7FFF_FFFF;
    // checked against the predictor from here on
    directed[9] = diag_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    directed[10] = diag_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    directed[11].m = {ONE, 32'h0, 32'h0, 32'h0, 32'h0, ONE, 32'h0, ONE, 32'h0};
    directed[12].m = {3 * ONE, ONE, 32'h0, -ONE, 2 * ONE, ONE, ONE, -ONE, 4 * ONE};
    directed[13].m = {ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                      7 * ONE, 8 * ONE, 10 * ONE};
    directed[14].m = {ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                      7 * ONE, 8 * ONE, 9 * ONE};
    directed[15] = diag_row(32'h0000_8000, 32'h0000_4000, 32'hFFFF_C000);
  end

  // Present one matrix after a random hold-off, then wait for the transaction.
  task automatic send_matrix(input logic [8:0][31:0] m, input int unsigned gap,
                             input logic typed, input inv_res_t typed_res);
    inv_res_t res;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int k = 0; k < 9; k++) in_m[k] <= m[k];
    start <= 1'b1;
    res = typed ? typed_res : invert_adjugate(m);
    @(posedge clk);
    while (busy) @(posedge clk);
    inverse_q.push_back(res);
    n_sent++;
  endtask

  // Stimulus: reset, directed table, random stream, then drain.
  initial begin
    int unsigned gap_hi;
    for (int k = 0; k < 9; k++) in_m[k] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < N_DIRECTED; k++)
      send_matrix(directed[k].m, $urandom_range(0, 18), directed[k].typed, directed[k].res);
    gap_hi = 18;
    for (int k = 0; k < N_RANDOM; k++) begin
      // every 64 items pick back-to-back bursts or random gaps
      if (k % 64 == 0) gap_hi = ($urandom_range(0, 2) == 0) ? 0 : 18;
      send_matrix(rand_matrix(), $urandom_range(0, gap_hi), 1'b0, '0);
    end
    start <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("Sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated).",
             n_sent, n_checked, n_singular, n_saturated);
    $display("Mismatches: %0d", n_mismatch);
    if (n_mismatch == 0 && inverse_q.size() == 0)
      $display("matrix3x3_inverse test passed");
    else
      $display("matrix3x3_inverse test failed");
    $finish;
  end

  // Check each result against the oldest prediction.
  always @(posedge clk) begin
    inv_res_t want;
    inv_res_t got;
    if (rst_n && out_valid) begin
      for (int k = 0; k < 9; k++) got.r[k] = out_r[k];
      got.det = out_det;
      got.sing = out_singular;
      if (inverse_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("ERROR: unexpected result, no matrix pending");
      end else begin
        want = inverse_q.pop_front();
        n_checked++;
        if (want.sing) n_singular++;
        for (int k = 0; k < 9; k++)
          if (want.r[k] == 32'h7FFF_FFFF || want.r[k] == 32'h8000_0000) begin
            n_saturated++;
            break;
          end
        for (int k = 0; k < 9; k++)
          if (got.r[k] !== want.r[k]) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("ERROR: result %0d entry r%0d%0d exp %h got %h",
                       n_checked, k / 3, k % 3, want.r[k], got.r[k]);
          end
        if (got.det !== want.det) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("ERROR: result %0d det exp %h got %h", n_checked, want.det, got.det);
        end
        if (got.sing !== want.sing) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("ERROR: result %0d singular exp %b got %b",
                     n_checked, want.sing, got.sing);
        end
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= STALL_MAX) begin
        $display("ERROR: watchdog timeout, %0d inverses outstanding", inverse_q.size());
        $display("matrix3x3_inverse test failed");
        $finish;
      end
    end
  end

endmodule
